// ===== rtl/gfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gfs_pkg;

    localparam int COEF_COUNT = 26;
    localparam int ACC_W      = 96;   // signed Q80 accumulator, -2^15 <= value < 2^15
    localparam int XMAG_W     = 31;   // magnitude of a Q3.28 argument, up to 2^30
    localparam int Q_W        = 51;   // quotient, clamped at 2^50
    localparam int OUT_W      = 48;
    localparam int DIV_STEPS  = 113;  // 2^112 / den, one quotient bit a step
    localparam int NUM_W      = 64;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [ACC_W-1:0]        t_mag;
    typedef logic [XMAG_W-1:0]       t_xmag;
    typedef logic [Q_W-1:0]          t_quo;

    localparam t_quo Q_CAP = {1'b1, {(Q_W-1){1'b0}}};

    // series coefficients as decimal fractions num / 10^exp, with their sign
    localparam logic [NUM_W-1:0] COEF_NUM [COEF_COUNT] = '{
        64'd1,            64'd5772156649,   64'd6558780715,   64'd42002635034,
        64'd16665386113,  64'd421977345555, 64'd96219715278,  64'd721894324666,
        64'd11651675918591, 64'd2152416741149, 64'd1280502823882, 64'd201348547807,
        64'd12504934821,  64'd11330272320,  64'd2056338417,   64'd61160950,
        64'd50020075,     64'd11812746,     64'd1043427,      64'd77823,
        64'd36968,        64'd51,           64'd206,          64'd54,
        64'd14,           64'd1
    };
    localparam int COEF_EXP [COEF_COUNT] = '{
        0, 10, 10, 12, 11, 13, 13, 14, 16, 16, 16, 16, 16,
        16, 16, 16, 16, 16, 16, 16, 16, 14, 16, 16, 17, 16
    };
    localparam logic COEF_NEG [COEF_COUNT] = '{
        1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0
    };

    // signed Q80 coefficient, magnitude rounded half up; elaboration only
    function automatic t_acc coef_q80(input int idx);
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
        logic [NUM_W-1:0] rem;
        t_mag             v;
        logic             nb;
        num = COEF_NUM[idx];
        den = 64'd1;
        rem = '0;
        v   = '0;
        for (int e = 0; e < COEF_EXP[idx]; e++) begin
            den = den * 64'd10;
        end
        for (int b = 0; b < NUM_W + 80; b++) begin
            nb  = (b < NUM_W) ? num[NUM_W-1-b] : 1'b0;
            rem = {rem[NUM_W-2:0], nb};
            v   = {v[ACC_W-2:0], 1'b0};
            if (rem >= den) begin
                rem  = rem - den;
                v[0] = 1'b1;
            end
        end
        if ({rem[NUM_W-2:0], 1'b0} >= den) begin
            v = v + t_mag'(1);
        end
        return COEF_NEG[idx] ? t_acc'(-v) : t_acc'(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gamma_function_series.sv =====
`timescale 1ns / 1ps
`default_nettype none

// gamma function over a stream of Q3.28 arguments in [-4, 4). each beat is
// run through the power series of 1/gamma (SERIES_TERMS terms, at most 26,
// Horner form, Q80 fixed point), then through a 113-step restoring divider
// that forms 2^112 / |sum|, giving gamma in signed Q15.32. one beat is
// accepted every cycle unless the pipe holds. there are four stages per
// Horner term (coefficient add, magnitude, three 32x31 partial products,
// product sum with rounding and sign), one stage for the divisor magnitude,
// one stage per quotient bit and one output register. the whole pipe holds
// while a finished beat waits at the output. a sum of exactly zero (x = 0
// for instance) gives the largest positive value with pole and saturated
// set; results beyond the output range are clamped with saturated set.

module gamma_function_series #(
    parameter int SERIES_TERMS = 26
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [30:0] x_value
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // [47:0] gamma_value
    output logic [1:0]       o_m_axis_tuser    // [0] saturated, [1] pole
);
    import gfs_pkg::*;

    localparam int TERMS = (SERIES_TERMS > COEF_COUNT) ? COEF_COUNT : SERIES_TERMS;

    // global advance: the pipe moves unless a result is held at the output
    logic w_en;
    logic r_vo;
    assign w_en            = !r_vo || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // input argument: sign and magnitude
    logic  w_xneg;
    t_xmag w_xmag;
    assign w_xneg = i_s_axis_tdata[30];
    assign w_xmag = w_xneg ? XMAG_W'(32'h8000_0000 - {1'b0, i_s_axis_tdata[30:0]})
                           : i_s_axis_tdata[30:0];

    // horner term stages
    t_acc        r_ta   [TERMS];
    t_mag        r_mag  [TERMS];
    logic [62:0] r_pp0  [TERMS];
    logic [62:0] r_pp1  [TERMS];
    logic [62:0] r_pp2  [TERMS];
    t_acc        r_acc  [TERMS];
    t_xmag       r_xm_a [TERMS];
    t_xmag       r_xm_b [TERMS];
    t_xmag       r_xm_c [TERMS];
    t_xmag       r_xm_d [TERMS];
    logic        r_xn_a [TERMS];
    logic        r_xn_b [TERMS];
    logic        r_xn_c [TERMS];
    logic        r_xn_d [TERMS];
    logic        r_sg_b [TERMS];
    logic        r_sg_c [TERMS];
    logic        r_va   [TERMS];
    logic        r_vb   [TERMS];
    logic        r_vc   [TERMS];
    logic        r_vd   [TERMS];

    for (genvar g = 0; g < TERMS; g++) begin : g_term
        localparam t_acc COEF = coef_q80(TERMS - 1 - g);

        t_acc         w_acc_in;
        t_xmag        w_xm_in;
        logic         w_xn_in;
        logic         w_v_in;
        logic [126:0] w_sum;
        t_mag         w_p;

        if (g == 0) begin : g_first
            assign w_acc_in = '0;
            assign w_xm_in  = w_xmag;
            assign w_xn_in  = w_xneg;
            assign w_v_in   = i_s_axis_tvalid;
        end else begin : g_next
            assign w_acc_in = r_acc[g-1];
            assign w_xm_in  = r_xm_d[g-1];
            assign w_xn_in  = r_xn_d[g-1];
            assign w_v_in   = r_vd[g-1];
        end

        // rounded product: (mag * x + 2^27) >> 28
        assign w_sum = 127'(r_pp0[g]) + (127'(r_pp1[g]) << 32)
                     + (127'(r_pp2[g]) << 64) + (127'(1) << 27);
        assign w_p   = w_sum[ACC_W+27:28];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va[g] <= 1'b0;
                r_vb[g] <= 1'b0;
                r_vc[g] <= 1'b0;
                r_vd[g] <= 1'b0;
            end else if (w_en) begin
                r_va[g] <= w_v_in;
                r_vb[g] <= r_va[g];
                r_vc[g] <= r_vb[g];
                r_vd[g] <= r_vc[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ta[g]   <= w_acc_in + COEF;
                r_xm_a[g] <= w_xm_in;
                r_xn_a[g] <= w_xn_in;

                r_mag[g]  <= r_ta[g][ACC_W-1] ? t_mag'(-r_ta[g]) : t_mag'(r_ta[g]);
                r_sg_b[g] <= r_ta[g][ACC_W-1] ^ r_xn_a[g];
                r_xm_b[g] <= r_xm_a[g];
                r_xn_b[g] <= r_xn_a[g];

                r_pp0[g]  <= {31'd0, r_mag[g][31:0]}  * {32'd0, r_xm_b[g]};
                r_pp1[g]  <= {31'd0, r_mag[g][63:32]} * {32'd0, r_xm_b[g]};
                r_pp2[g]  <= {31'd0, r_mag[g][95:64]} * {32'd0, r_xm_b[g]};
                r_sg_c[g] <= r_sg_b[g];
                r_xm_c[g] <= r_xm_b[g];
                r_xn_c[g] <= r_xn_b[g];

                r_acc[g]  <= r_sg_c[g] ? t_acc'(-w_p) : t_acc'(w_p);
                r_xm_d[g] <= r_xm_c[g];
                r_xn_d[g] <= r_xn_c[g];
            end
        end
    end

    // divisor magnitude, sign and pole detect
    t_mag r_den_e;
    logic r_neg_e;
    logic r_pole_e;
    logic r_ve;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (w_en) begin
            r_ve <= r_vd[TERMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg_e  <= r_acc[TERMS-1][ACC_W-1];
            r_den_e  <= r_acc[TERMS-1][ACC_W-1] ? t_mag'(-r_acc[TERMS-1])
                                                : t_mag'(r_acc[TERMS-1]);
            r_pole_e <= (r_acc[TERMS-1] == '0);
        end
    end

    // restoring divider, one quotient bit per stage
    t_mag r_rem  [DIV_STEPS];
    t_quo r_q    [DIV_STEPS];
    t_mag r_den  [DIV_STEPS];
    logic r_neg  [DIV_STEPS];
    logic r_pole [DIV_STEPS];
    logic r_vq   [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        t_mag          w_rem_in;
        t_quo          w_q_in;
        t_mag          w_den_in;
        logic          w_neg_in;
        logic          w_pole_in;
        logic          w_v_in;
        logic [ACC_W:0] w_rs;
        logic          w_ge;
        logic [Q_W:0]  w_qs;

        if (j == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_q_in    = '0;
            assign w_den_in  = r_den_e;
            assign w_neg_in  = r_neg_e;
            assign w_pole_in = r_pole_e;
            assign w_v_in    = r_ve;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_q_in    = r_q[j-1];
            assign w_den_in  = r_den[j-1];
            assign w_neg_in  = r_neg[j-1];
            assign w_pole_in = r_pole[j-1];
            assign w_v_in    = r_vq[j-1];
        end

        // the dividend 2^112 brings a single one in at the first step
        assign w_rs = {w_rem_in, (j == 0) ? 1'b1 : 1'b0};
        assign w_ge = (w_rs >= {1'b0, w_den_in});
        assign w_qs = {w_q_in, w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vq[j] <= 1'b0;
            end else if (w_en) begin
                r_vq[j] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[j]  <= w_ge ? ACC_W'(w_rs - {1'b0, w_den_in}) : w_rs[ACC_W-1:0];
                // quotient clamps once it passes 2^50, far beyond the output range
                r_q[j]    <= (w_qs > {1'b0, Q_CAP}) ? Q_CAP : w_qs[Q_W-1:0];
                r_den[j]  <= w_den_in;
                r_neg[j]  <= w_neg_in;
                r_pole[j] <= w_pole_in;
            end
        end
    end

    // rounding, saturation and output register
    localparam int L = DIV_STEPS - 1;

    logic           w_rnd;
    logic [Q_W:0]   w_qr;
    logic [Q_W:0]   w_lim;
    logic           w_sat;
    logic [OUT_W-1:0] w_qc;
    logic [OUT_W-1:0] w_g;

    assign w_rnd = ({r_rem[L], 1'b0} >= {1'b0, r_den[L]});
    assign w_qr  = {1'b0, r_q[L]} + (Q_W+1)'(w_rnd);
    assign w_lim = r_neg[L] ? ((Q_W+1)'(1) << (OUT_W-1))
                            : (((Q_W+1)'(1) << (OUT_W-1)) - (Q_W+1)'(1));
    assign w_sat = (w_qr > w_lim);
    assign w_qc  = w_sat ? w_lim[OUT_W-1:0] : w_qr[OUT_W-1:0];
    assign w_g   = r_neg[L] ? (-w_qc) : w_qc;

    logic [OUT_W-1:0] r_gamma;
    logic             r_sat;
    logic             r_pole_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_vo <= r_vq[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_pole[L]) begin
                r_gamma  <= {1'b0, {(OUT_W-1){1'b1}}};
                r_sat    <= 1'b1;
                r_pole_o <= 1'b1;
            end else begin
                r_gamma  <= w_g;
                r_sat    <= w_sat;
                r_pole_o <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = r_gamma;
    assign o_m_axis_tuser  = {r_pole_o, r_sat};

endmodule

`default_nettype wire

// ===== tb/gamma_function_series_tb.sv =====
`timescale 1ns / 1ps

module gamma_function_series_tb;

    localparam int TERMS       = 26;
    localparam int LATENCY     = 4 * TERMS + 115;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [47:0] gamma;
        logic        sat;
        logic        pole;
    } gamma_res_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic [31:0] s_data;      // [30:0] x_value
    logic        m_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;   // [47:0] gamma_value
    logic [1:0]  o_m_axis_tuser;   // [0] saturated, [1] pole

    gamma_function_series #(.SERIES_TERMS(TERMS)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // series coefficients c[1..26] as num / 10^exp with a sign
    localparam logic [63:0] SER_NUM [26] = '{
        64'd1, 64'd5772156649, 64'd6558780715, 64'd42002635034, 64'd16665386113,
        64'd421977345555, 64'd96219715278, 64'd721894324666, 64'd11651675918591,
        64'd2152416741149, 64'd1280502823882, 64'd201348547807, 64'd12504934821,
        64'd11330272320, 64'd2056338417, 64'd61160950, 64'd50020075, 64'd11812746,
        64'd1043427, 64'd77823, 64'd36968, 64'd51, 64'd206, 64'd54, 64'd14, 64'd1
    };
    localparam int SER_EXP [26] = '{
        0, 10, 10, 12, 11, 13, 13, 14, 16, 16, 16, 16, 16,
        16, 16, 16, 16, 16, 16, 16, 16, 14, 16, 16, 17, 16
    };
    localparam bit SER_NEG [26] = '{
        0, 0, 1, 1, 0, 1, 1, 0, 1, 1, 0, 1, 1,
        0, 1, 0, 0, 1, 0, 0, 1, 0, 1, 1, 0, 0
    };

    gamma_res_t gamma_expected[$];
    int         err_count;
    int         src_idle;
    int         snk_stall;
    int         hold_cycles;
    int         quiet_cycles;

    // free-running clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Q80 coefficient magnitude, rounded half up
    function automatic logic [127:0] coef_mag(input int idx);
        logic [159:0] den;
        logic [159:0] q2;
        den = 160'd1;
        for (int e = 0; e < SER_EXP[idx]; e++) begin
            den = den * 160'd10;
        end
        q2 = ({96'd0, SER_NUM[idx]} << 81) / den;
        return 128'((q2 + 160'd1) >> 1);
    endfunction

    // gamma(x) through the reciprocal series and a rounded division
    function automatic gamma_res_t gamma_of(input logic [30:0] x);
        logic          xneg;
        logic [31:0]   xmag;
        logic [127:0]  acc;
        logic [127:0]  t;
        logic [127:0]  tmag;
        logic [127:0]  cq;
        logic [159:0]  p;
        logic [127:0]  den;
        logic [127:0]  qf;
        logic [127:0]  rm;
        logic [127:0]  q;
        logic [127:0]  lim;
        logic          neg;
        gamma_res_t    r;
        xneg = x[30];
        xmag = xneg ? (32'h8000_0000 - {1'b0, x}) : {1'b0, x};
        acc  = '0;
        for (int k = TERMS; k >= 1; k--) begin
            cq   = coef_mag(k - 1);
            t    = acc + (SER_NEG[k-1] ? -cq : cq);
            tmag = t[127] ? -t : t;
            p    = ({32'd0, tmag} * {128'd0, xmag} + 160'd134217728) >> 28;
            acc  = (t[127] != xneg) ? -p[127:0] : p[127:0];
        end
        r = '0;
        if (acc == '0) begin
            r.gamma = 48'h7FFF_FFFF_FFFF;
            r.sat   = 1'b1;
            r.pole  = 1'b1;
            return r;
        end
        neg = acc[127];
        den = neg ? -acc : acc;
        qf  = (128'd1 << 112) / den;
        rm  = (128'd1 << 112) % den;
        lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
        if (qf > (128'd1 << 50)) begin
            q = qf;
        end else begin
            q = qf + ((rm << 1) >= den);
        end
        if (q > lim) begin
            q     = lim;
            r.sat = 1'b1;
        end
        r.gamma = neg ? 48'(-q) : q[47:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // one argument beat; the expectation is queued when it is accepted
    task automatic send_x(input logic [30:0] x);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {1'b0, x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        gamma_expected.push_back(gamma_of(x));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_valid <= 1'b0;
    endtask

    // sender holds off until the pipe has drained
    task automatic wait_drain();
        stop_sending();
        while (gamma_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // random argument: mostly full range, some near integers and poles
    function automatic logic [30:0] rand_x();
        int sel;
        logic [30:0] base;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 31'($urandom);
        base = 31'(($urandom_range(0, 7) - 4) << 28);
        if (sel < 9) return base + 31'($urandom_range(0, 64)) - 31'd32;
        return base;
    endfunction

    task automatic test_directed();
        logic [30:0] pts [$];
        pts = '{31'h0, 31'h4000_0000, 31'h3FFF_FFFF, 31'h1000_0000, 31'h7000_0000,
                31'h0800_0000, 31'h0000_0001, 31'h7FFF_FFFF, 31'h2000_0000,
                31'h3000_0000, 31'h6000_0000, 31'h5000_0000, 31'h7800_0000,
                31'h1800_0000, 31'h0000_1000, 31'h7FFF_F000, 31'h2AAA_AAAA,
                31'h5555_5555, 31'h4000_0001, 31'h0FFF_FFFF};
        src_idle  = 0;
        snk_stall = 0;
        foreach (pts[i]) send_x(pts[i]);
        wait_drain();
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        src_idle  = idle_pct;
        snk_stall = stall_pct;
        repeat (n) send_x(rand_x());
    endtask

    // receiver holds off while arguments keep coming, so the input stalls
    task automatic test_backpressure();
        src_idle    = 0;
        snk_stall   = 0;
        hold_cycles = 600;
        repeat (230) send_x(rand_x());
        wait_drain();
    endtask

    // receiver ready, with random stalls and a long hold on request
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_stall);
        end
    end

    // result check and stall watchdog
    always @(posedge i_clk) begin
        gamma_res_t want;
        if (i_rst_n) begin
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (o_m_axis_tvalid && m_ready) begin
                if (gamma_expected.size() == 0) begin
                    report_mismatch("unexpected beat", o_m_axis_tdata, '0);
                end else begin
                    want = gamma_expected.pop_front();
                    if (o_m_axis_tdata !== want.gamma)
                        report_mismatch("gamma", o_m_axis_tdata, want.gamma);
                    if (o_m_axis_tuser[0] !== want.sat)
                        report_mismatch("saturated", 48'(o_m_axis_tuser[0]), 48'(want.sat));
                    if (o_m_axis_tuser[1] !== want.pole)
                        report_mismatch("pole", 48'(o_m_axis_tuser[1]), 48'(want.pole));
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        err_count    = 0;
        src_idle     = 0;
        snk_stall    = 0;
        hold_cycles  = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(70, 0, 0);
        test_random(70, 64, 0);
        test_random(70, 0, 64);
        test_random(70, 34, 34);
        test_backpressure();
        test_random(20, 0, 0);

        stop_sending();
        while (gamma_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gfs_pkg.sv
rtl/gamma_function_series.sv
tb/gamma_function_series_tb.sv
